>>> hw/rtl/utf8_pkg.sv
// ----------------------------------------------------------------------------
// utf8_pkg
// Shared types, constants and the character assembly function for the
// UTF-8 / ANSI byte stream decoder.
// ----------------------------------------------------------------------------
package utf8_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgTextMode   = 2'd0;
  localparam logic [1:0] CfgWideChars  = 2'd1;
  localparam logic [1:0] CfgCountLines = 2'd2;

  localparam int unsigned CharW = 21;
  localparam int unsigned LineW = 32;

  localparam logic [CharW-1:0] QMark   = CharW'(63);
  localparam logic [7:0]       Newline = 8'h0A;

  typedef struct packed {
    logic [CharW-1:0] char_value;
    logic [2:0]       seq_bytes;
    logic             cut_short;
    logic [LineW-1:0] line_count;
  } res_t;

  // Build a character from its lead byte and collected payload by length
  function automatic logic [CharW-1:0] decode_char(input logic [7:0]  lead,
                                                   input logic [17:0] cont,
                                                   input logic [2:0]  n,
                                                   input logic        wide);
    logic [CharW-1:0] v;
    case (n)
      3'd2:    v = {10'd0, lead[4:0], cont[5:0]};
      3'd3:    v = {5'd0, lead[3:0], cont[11:0]};
      3'd4:    v = {lead[2:0], cont};
      default: v = {14'd0, lead[6:0]};
    endcase
    if (n > 3'd1 && !wide) begin
      v = QMark;
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/utf8_byte_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit
// Byte-serial UTF-8 / ANSI decoder: one byte per beat in, one character out
// when its sequence completes or the stream ends early.
// A completed result is registered into the output register, or into the skid
// entry while the output is stalled. Throughput: one byte per cycle while
// in_stall_o is low; a two-entry output buffer absorbs one stalled beat.
// Reset: sequence state, line counter and buffer cleared; wide_chars set,
// text_mode and count_lines cleared.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit
  import utf8_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic             cfg_wdata_i,
  // byte input
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             stream_end_i,
  // character output
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CharW-1:0] char_value_o,
  output logic [2:0]       seq_bytes_o,
  output logic             cut_short_o,
  output logic [LineW-1:0] line_count_o
);

  logic text_mode_q, wide_chars_q, count_lines_q;

  logic [7:0]       lead_q, lead_d;
  logic [17:0]      cont_q, cont_d;
  logic [1:0]       need_q, need_d;
  logic [2:0]       held_q, held_d;
  logic [LineW-1:0] line_q, line_d;

  logic  res_vld;
  res_t  res;
  logic  out_vld_q, skid_vld_q;
  res_t  out_q, skid_q;

  logic accept, out_free;
  logic [17:0] cont_shift;
  logic [2:0]  held_inc;
  logic [1:0]  lead_need;

  assign in_stall_o = skid_vld_q;
  assign accept     = in_valid_i && !skid_vld_q;
  assign out_free   = !out_vld_q || !out_stall_i;

  assign cont_shift = {cont_q[11:0], data_byte_i[5:0]};
  assign held_inc   = held_q + 3'd1;

  always_comb begin
    if (data_byte_i[7:4] == 4'hF) begin
      lead_need = 2'd3;
    end else if (data_byte_i[7:5] == 3'b111) begin
      lead_need = 2'd2;
    end else if (data_byte_i[7:6] == 2'b11) begin
      lead_need = 2'd1;
    end else begin
      lead_need = 2'd0;
    end
  end

  // Sequence state update and result assembly
  always_comb begin
    lead_d  = lead_q;
    cont_d  = cont_q;
    need_d  = need_q;
    held_d  = held_q;
    line_d  = line_q;
    res_vld = 1'b0;
    res     = '{char_value: decode_char(lead_q, cont_q, held_q, wide_chars_q),
                seq_bytes:  held_q,
                cut_short:  1'b0,
                line_count: line_q};
    if (accept) begin
      if (stream_end_i) begin
        if (held_q != 3'd0) begin
          res_vld       = 1'b1;
          res.cut_short = 1'b1;
          lead_d = '0;
          cont_d = '0;
          need_d = '0;
          held_d = '0;
        end
      end else if (need_q != 2'd0) begin
        if (need_q == 2'd1) begin
          res_vld        = 1'b1;
          res.char_value = decode_char(lead_q, cont_shift, held_inc, wide_chars_q);
          res.seq_bytes  = held_inc;
          lead_d = '0;
          cont_d = '0;
          need_d = '0;
          held_d = '0;
        end else begin
          cont_d = cont_shift;
          held_d = held_inc;
          need_d = need_q - 2'd1;
        end
      end else if (text_mode_q) begin
        res_vld        = 1'b1;
        res.char_value = data_byte_i[7] ? QMark : {14'd0, data_byte_i[6:0]};
        res.seq_bytes  = 3'd1;
      end else begin
        if (count_lines_q && data_byte_i == Newline) begin
          line_d = line_q + LineW'(1);
        end
        res.line_count = line_d;
        if (lead_need == 2'd0) begin
          // single-byte character, stray continuation bytes included
          res_vld        = 1'b1;
          res.char_value = {14'd0, data_byte_i[6:0]};
          res.seq_bytes  = 3'd1;
        end else begin
          lead_d = data_byte_i;
          cont_d = '0;
          held_d = 3'd1;
          need_d = lead_need;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_mode_q   <= 1'b0;
      wide_chars_q  <= 1'b1;
      count_lines_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTextMode:   text_mode_q   <= cfg_wdata_i;
        CfgWideChars:  wide_chars_q  <= cfg_wdata_i;
        CfgCountLines: count_lines_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      cont_q <= '0;
      need_q <= '0;
      held_q <= '0;
      line_q <= '0;
    end else begin
      lead_q <= lead_d;
      cont_q <= cont_d;
      need_q <= need_d;
      held_q <= held_d;
      line_q <= line_d;
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_free) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (res_vld) begin
      if (out_free) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_free) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (res_vld) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign char_value_o = out_q.char_value;
  assign seq_bytes_o  = out_q.seq_bytes;
  assign cut_short_o  = out_q.cut_short;
  assign line_count_o = out_q.line_count;

endmodule

>>> dv/utf8_byte_stream_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit_tb
// Self-checking bench for the byte stream decoder. A queue of pending beats,
// register writes and drain points feeds a clocked driver. Every accepted byte
// goes through a cycle-free model of the decoder that predicts the next
// character. A clocked monitor stalls the output at random and compares each
// character it receives, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit_tb
  import utf8_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned ByteTarget   = 400;

  typedef enum logic [1:0] {ItemByte, ItemCfg, ItemDrain, ItemCalm} item_kind_e;

  typedef struct {
    item_kind_e kind;
    logic [7:0] data;
    logic       eos;
    logic [1:0] idx;
    logic       val;
  } item_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_we_i     = 1'b0;
  logic [1:0]       cfg_idx_i    = CfgTextMode;
  logic             cfg_wdata_i  = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic [7:0]       data_byte_i  = 8'h00;
  logic             stream_end_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [CharW-1:0] char_value_o;
  logic [2:0]       seq_bytes_o;
  logic             cut_short_o;
  logic [LineW-1:0] line_count_o;

  utf8_byte_stream_decoder_unit i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .stream_end_i,
    .out_valid_o,
    .out_stall_i,
    .char_value_o,
    .seq_bytes_o,
    .cut_short_o,
    .line_count_o
  );

  // Decoder model state and its copy of the registers
  logic             mode_ansi   = 1'b0;
  logic             mode_wide   = 1'b1;
  logic             mode_count  = 1'b0;
  logic [7:0]       seq_lead    = '0;
  logic [17:0]      seq_payload = '0;
  logic [1:0]       seq_left    = '0;
  logic [2:0]       seq_held    = '0;
  logic [LineW-1:0] line_total  = '0;

  item_t       item_q[$];
  res_t        char_exp_q[$];
  int unsigned byte_cnt     = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned settle       = 0;
  logic        calm         = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------
  function automatic void add_char(input res_t r);
    char_exp_q = {char_exp_q, r};
  endfunction

  function automatic void close_char(input logic cut);
    res_t             r;
    logic [CharW-1:0] v;
    case (seq_held)
      3'd2:    v = (CharW'(seq_lead & 8'h1F) << 6)  | CharW'(seq_payload & 18'h0003F);
      3'd3:    v = (CharW'(seq_lead & 8'h0F) << 12) | CharW'(seq_payload & 18'h00FFF);
      3'd4:    v = (CharW'(seq_lead & 8'h07) << 18) | CharW'(seq_payload);
      default: v = CharW'(seq_lead & 8'h7F);
    endcase
    if (seq_held > 3'd1 && !mode_wide) begin
      v = QMark;
    end
    r.char_value = v;
    r.seq_bytes  = seq_held;
    r.cut_short  = cut;
    r.line_count = line_total;
    add_char(r);
    seq_lead    = '0;
    seq_payload = '0;
    seq_left    = '0;
    seq_held    = '0;
  endfunction

  function automatic void decode_beat(input logic [7:0] b, input logic eos);
    res_t r;
    if (eos) begin
      if (seq_held != 3'd0) begin
        close_char(1'b1);
      end
    end else if (seq_left != 2'd0) begin
      // pending sequence takes any byte as continuation, whatever the mode
      seq_payload = {seq_payload[11:0], b[5:0]};
      seq_held    = seq_held + 3'd1;
      seq_left    = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        close_char(1'b0);
      end
    end else if (mode_ansi) begin
      r.char_value = b[7] ? QMark : CharW'(b);
      r.seq_bytes  = 3'd1;
      r.cut_short  = 1'b0;
      r.line_count = line_total;
      add_char(r);
    end else begin
      if (mode_count && b == Newline) begin
        line_total = line_total + LineW'(1);
      end
      seq_lead    = b;
      seq_payload = '0;
      seq_held    = 3'd1;
      if (b[7:4] == 4'hF) begin
        seq_left = 2'd3;
      end else if (b[7:5] == 3'b111) begin
        seq_left = 2'd2;
      end else if (b[7:6] == 2'b11) begin
        seq_left = 2'd1;
      end else begin
        seq_left = 2'd0;
      end
      if (seq_left == 2'd0) begin
        close_char(1'b0);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue helpers
  // ---------------------------------------------------------------------------
  function automatic void push_item(input item_kind_e kind, input logic [7:0] data,
                                    input logic eos, input logic [1:0] idx, input logic val);
    item_t it;
    it.kind = kind;
    it.data = data;
    it.eos  = eos;
    it.idx  = idx;
    it.val  = val;
    item_q = {item_q, it};
    if (kind == ItemByte) begin
      byte_cnt++;
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    push_item(ItemByte, b, 1'b0, CfgTextMode, 1'b0);
  endfunction

  // data lines carry junk on an end-of-stream beat
  function automatic void push_end();
    push_item(ItemByte, 8'($urandom_range(255)), 1'b1, CfgTextMode, 1'b0);
  endfunction

  function automatic void push_cfg(input logic [1:0] idx, input logic val);
    push_item(ItemCfg, 8'h00, 1'b0, idx, val);
  endfunction

  // One character of n bytes with random content; cut short ends the stream early
  function automatic void push_char(input int unsigned n, input bit cut);
    logic [7:0]  lead;
    int unsigned conts;
    case (n)
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      4:       lead = {4'b1111, 4'($urandom)};
      default: lead = 8'($urandom_range(8'hBF));
    endcase
    push_byte(lead);
    conts = cut ? $urandom_range(n - 2, 0) : n - 1;
    repeat (conts) begin
      if ($urandom_range(9) == 0) begin
        push_byte(8'($urandom_range(255)));
      end else begin
        push_byte({2'b10, 6'($urandom)});
      end
    end
    if (cut) begin
      push_end();
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(30, 8);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: byte beats, register writes only once everything has drained
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    item_t head;
    logic  hold;
    logic  nv;
    logic  nwe;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_we_i   <= 1'b0;
    end else begin
      hold = in_valid_i && in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        decode_beat(data_byte_i, stream_end_i);
      end
      nv  = hold;
      nwe = 1'b0;
      if (!hold && item_q.size() != 0) begin
        head = item_q[0];
        if (head.kind == ItemByte) begin
          settle = 0;
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            head = item_q.pop_front();
            data_byte_i  <= head.data;
            stream_end_i <= head.eos;
            nv       = 1'b1;
            gap_left = pick_gap();
          end
        end else if (char_exp_q.size() != 0) begin
          settle = 0;
        end else if (settle < SettleCycles) begin
          // a byte that completes nothing may still be in flight
          settle++;
        end else begin
          head   = item_q.pop_front();
          settle = 0;
          case (head.kind)
            ItemCfg: begin
              nwe = 1'b1;
              cfg_idx_i   <= head.idx;
              cfg_wdata_i <= head.val;
              case (head.idx)
                CfgTextMode:   mode_ansi  = head.val;
                CfgWideChars:  mode_wide  = head.val;
                CfgCountLines: mode_count = head.val;
                default: ;
              endcase
            end
            ItemCalm: calm = head.val;
            default: ;
          endcase
        end
      end
      in_valid_i <= nv;
      cfg_we_i   <= nwe;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (char_exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%0h", char_value_o));
        end else begin
          want = char_exp_q.pop_front();
          check_field("char_value", 32'(char_value_o), 32'(want.char_value));
          check_field("seq_bytes", 32'(seq_bytes_o), 32'(want.seq_bytes));
          check_field("cut_short", 32'(cut_short_o), 32'(want.cut_short));
          check_field("line_count", line_count_o, want.line_count);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(99) < 20) begin
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned r;

    // directed: reset settings are UTF-8, wide, no line counting
    push_byte(8'h00);
    push_byte(Newline);
    push_byte(8'h80);                       // stray continuation
    push_byte(8'hC3); push_byte(8'hA9);
    push_byte(8'hE2); push_byte(8'h82); push_byte(8'hAC);
    push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
    push_end();                             // nothing pending, no character
    push_byte(8'hE2); push_byte(8'h82); push_end();
    push_byte(8'hF0); push_end();           // lone lead flushed
    push_cfg(CfgCountLines, 1'b1);
    push_byte(Newline);
    push_cfg(CfgWideChars, 1'b0);
    push_byte(8'hC3); push_byte(8'hA9);
    // switch to ANSI while a sequence is open
    push_byte(8'hE2);
    push_cfg(CfgTextMode, 1'b1);
    push_byte(8'h82); push_byte(8'hAC);
    push_byte(Newline); push_byte(8'hFF);
    push_cfg(CfgTextMode, 1'b0);
    push_byte(8'hC3);
    push_cfg(CfgWideChars, 1'b1);           // sampled when the last byte completes the character
    push_byte(8'hA9);

    phase = 0;
    while (byte_cnt < ByteTarget) begin
      r = (phase < 8) ? phase : $urandom_range(7);
      push_cfg(CfgTextMode,   r[0] && ($urandom_range(2) == 0 || phase < 8));
      push_cfg(CfgWideChars,  r[1]);
      push_cfg(CfgCountLines, r[2]);
      push_item(ItemCalm, 8'h00, 1'b0, CfgTextMode, $urandom_range(3) == 0);
      repeat ($urandom_range(70, 30)) begin
        if (byte_cnt >= ByteTarget) begin
          break;
        end
        r = $urandom_range(99);
        if (r < 8) begin
          push_byte(Newline);
        end else if (r < 78) begin
          push_char($urandom_range(4, 1), 1'b0);
        end else if (r < 86) begin
          push_char($urandom_range(4, 2), 1'b1);
        end else if (r < 93) begin
          push_byte(8'($urandom_range(255)));
        end else if (r < 97) begin
          push_end();
        end else begin
          push_item(ItemDrain, 8'h00, 1'b0, CfgTextMode, 1'b0);
        end
      end
      phase++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do begin
      @(posedge clk_i);
    end while (item_q.size() != 0 || in_valid_i || char_exp_q.size() != 0);
    // last beat may still be on its way and the output held by a long stall
    repeat (50) @(posedge clk_i);

    if (mismatch_cnt == 0 && char_exp_q.size() == 0) begin
      $display("utf8_byte_stream_decoder_unit test passed");
    end else begin
      $display("utf8_byte_stream_decoder_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TIMEOUT with %0d characters outstanding", char_exp_q.size());
    $display("utf8_byte_stream_decoder_unit test failed");
    $finish;
  end

endmodule
